@@ rtl/b62enc_pkg.sv @@
// shared constants, types and digit mapping for the base-62 encoder
package b62enc_pkg;

    localparam int MAX_DIGITS   = 11;
    localparam int MAX_PAD      = 32;
    localparam int RADIX        = 62;
    localparam int VALUE_W      = 64;
    localparam int CHUNK_W      = 16;
    localparam int NUM_CHUNKS   = VALUE_W / CHUNK_W;
    localparam int DIGIT_W      = 6;
    localparam int COUNT_W      = 4;
    localparam int LEN_W        = 6;
    localparam int CHAR_W       = 7;
    localparam int QUEUE_DEPTH  = 2;

    // one long-division step: {remainder, chunk} divided by 62
    localparam int DIVIDEND_W   = DIGIT_W + CHUNK_W;
    localparam int RECIP_SHIFT  = 28;
    localparam int RECIP_W      = 23;
    localparam logic [RECIP_W-1:0] RECIP_62 = RECIP_W'((64'd1 << RECIP_SHIFT) / RADIX + 1);

    localparam logic [CHAR_W-1:0] CHAR_0 = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7a;

    typedef logic [DIGIT_W-1:0] digit_t;

    // one converted value handed from the front to the back
    typedef struct packed {
        digit_t [MAX_DIGITS-1:0] digits;
        logic   [COUNT_W-1:0]    count;
    } job_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input digit_t d);
        logic [CHAR_W-1:0] c;
        begin
            if (d < 6'd10)
            begin
                c = CHAR_0 + CHAR_W'(d);
            end
            else if (d < 6'd36)
            begin
                c = CHAR_A + CHAR_W'(d - 6'd10);
            end
            else if (d < 6'd62)
            begin
                c = CHAR_LOWER_A + CHAR_W'(d - 6'd36);
            end
            else
            begin
                c = CHAR_LOWER_Z;
            end
            return c;
        end
    endfunction

endpackage

@@ rtl/b62enc_front.sv @@
// front end: accepts a value and converts it to base-62 digits by repeated division
module b62enc_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [63:0]                 value,
    output logic                        busy,
    output logic                        push,
    output b62enc_pkg::job_t            push_job,
    input  logic                        queue_full
);
    import b62enc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam int IDX_W = $clog2(NUM_CHUNKS);

    logic [1:0]              state_reg, state_next;
    logic [VALUE_W-1:0]      val_reg, val_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    digit_t                  digit_buf [MAX_DIGITS];

    logic [CHUNK_W-1:0]              chunk;
    logic [DIVIDEND_W-1:0]           dividend;
    logic [DIVIDEND_W+RECIP_W-1:0]   product;
    logic [CHUNK_W-1:0]              quot_chunk;
    logic [DIVIDEND_W-1:0]           quot_times_radix;
    logic [DIGIT_W-1:0]              step_rem;
    logic [VALUE_W-1:0]              quot_value;
    logic                            accept;
    logic                            buf_we;
    logic [COUNT_W-1:0]              buf_addr;
    digit_t                          buf_wdata;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // reciprocal multiply is exact since the dividend stays below 62 * 2^16
    assign chunk            = val_reg[idx_reg*CHUNK_W +: CHUNK_W];
    assign dividend         = {rem_reg, chunk};
    assign product          = dividend * RECIP_62;
    assign quot_chunk       = product[RECIP_SHIFT +: CHUNK_W];
    assign quot_times_radix = {DIGIT_W'(0), quot_chunk} * DIVIDEND_W'(RADIX);
    assign step_rem         = DIGIT_W'(dividend - quot_times_radix);

    always_comb
    begin
        quot_value = val_reg;
        quot_value[idx_reg*CHUNK_W +: CHUNK_W] = quot_chunk;
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        buf_we     = 1'b0;
        buf_addr   = count_reg;
        buf_wdata  = step_rem;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next = value;
                    idx_next = IDX_W'(NUM_CHUNKS - 1);
                    rem_next = '0;
                    if (value == '0)
                    begin
                        // zero encodes as a single digit 0
                        buf_we     = 1'b1;
                        buf_addr   = '0;
                        buf_wdata  = '0;
                        count_next = COUNT_W'(1);
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                val_next = quot_value;
                idx_next = idx_reg - 1'b1;
                rem_next = step_rem;
                if (idx_reg == '0)
                begin
                    // remainder after the lowest chunk is the next digit
                    buf_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    idx_next   = IDX_W'(NUM_CHUNKS - 1);
                    if ((quot_value == '0) || (count_reg == COUNT_W'(MAX_DIGITS - 1)))
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (buf_we)
        begin
            digit_buf[buf_addr] <= buf_wdata;
        end
    end

    assign push = (state_reg == ST_PUSH) && !queue_full;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            push_job.digits[i] = digit_buf[i];
        end
        push_job.count = count_reg;
    end

endmodule

@@ rtl/b62enc_queue.sv @@
// two-entry queue of converted digit sets between front and back
module b62enc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b62enc_pkg::job_t     push_job,
    output logic                 full,
    input  logic                 pop,
    output b62enc_pkg::job_t     head_job,
    output logic                 empty
);
    import b62enc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_job = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/b62enc_back.sv @@
// back end: holds the minimum length and emits padding and digit characters
module b62enc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [5:0]                 cfg_data,
    input  logic                       queue_empty,
    input  b62enc_pkg::job_t           head_job,
    output logic                       pop,
    output logic                       strobe,
    output logic [6:0]                 character,
    output logic                       last
);
    import b62enc_pkg::*;

    logic [LEN_W-1:0]    min_len_reg;
    logic                active_reg;
    logic [LEN_W-1:0]    remaining_reg;
    job_t                job_reg;

    logic [LEN_W-1:0]    head_count;
    logic [LEN_W-1:0]    head_total;
    logic                finishing;
    logic [COUNT_W-1:0]  digit_idx;

    assign cfg_ready = 1'b1;

    assign head_count = LEN_W'(head_job.count);
    assign head_total = (min_len_reg > head_count) ? min_len_reg : head_count;
    assign finishing  = active_reg && (remaining_reg == LEN_W'(1));
    assign pop        = !queue_empty && (!active_reg || finishing);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= '0;
            active_reg    <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_len_reg <= (cfg_data > LEN_W'(MAX_PAD)) ? LEN_W'(MAX_PAD) : cfg_data;
            end
            if (pop)
            begin
                active_reg    <= 1'b1;
                remaining_reg <= head_total;
            end
            else if (active_reg)
            begin
                remaining_reg <= remaining_reg - 1'b1;
                if (finishing)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
    end

    // positions above the digit count are leading pad characters
    assign digit_idx = COUNT_W'(remaining_reg - 1'b1);
    assign strobe    = active_reg;
    assign last      = finishing;

    always_comb
    begin
        if (remaining_reg > LEN_W'(job_reg.count))
        begin
            character = CHAR_0;
        end
        else
        begin
            character = digit_to_char(job_reg.digits[digit_idx]);
        end
    end

endmodule

@@ rtl/base62_integer_encoder.sv @@
// top level of the base-62 integer encoder
//
// An item is taken when start is high and busy is low. The front end converts the
// 64-bit value by long division over four 16-bit chunks, one chunk per cycle. The
// back end then emits max(d, min_length) characters for a value of d digits, one per
// cycle with strobe high, most significant first, and marks the final one with last.
// A two-entry queue lets the conversion of the next item overlap the output of
// earlier ones. Results cannot be held off: the receiver must take every strobed
// cycle. min_length writes above 32 are stored as 32; write it only while idle.
module base62_integer_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output logic        strobe,
    output logic [6:0]  character,
    output logic        last
);
    import b62enc_pkg::*;

    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;
    job_t   push_job;
    job_t   head_job;

    b62enc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .busy       (busy),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    b62enc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    b62enc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (pop),
        .strobe      (strobe),
        .character   (character),
        .last        (last)
    );

endmodule
